FILE: design/oaht_pkg.sv
// Shared constants, result codes and controller/datapath interface types.
`timescale 1ns / 1ps

package oaht_pkg;

  localparam int TableSlots = 128;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int KeyBytes   = 12;
  localparam int HalfKeyW   = 48;
  localparam int KeyW       = 2 * HalfKeyW;
  localparam int QtyW       = 16;
  localparam int HashW      = 32;
  localparam int StatusW    = 3;
  localparam int ModeW      = 2;
  localparam int HashCycles = KeyBytes / 2;
  localparam int HcntW      = (HashCycles > 1) ? $clog2(HashCycles) : 1;
  localparam int ProbeW     = SlotW + 1;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  localparam logic [ModeW-1:0] ModeLinear = 2'd0;
  localparam logic [ModeW-1:0] ModeQuad   = 2'd1;
  localparam logic [ModeW-1:0] ModeDouble = 2'd2;

  localparam logic [StatusW-1:0] StatInserted = 3'd0;
  localparam logic [StatusW-1:0] StatAdded    = 3'd1;
  localparam logic [StatusW-1:0] StatFound    = 3'd2;
  localparam logic [StatusW-1:0] StatNotFound = 3'd3;
  localparam logic [StatusW-1:0] StatFull     = 3'd4;

  typedef struct packed {
    logic load;
    logic hash;
    logic fold;
    logic probe;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic hit;
    logic exhausted;
  } dp_sts_t;

endpackage

FILE: design/open_address_hash_table.sv
// Top level of the open-addressed hash table: controller, datapath and checks.
//
// An item is taken when start is high and busy is low; its result appears on
// status_o, slot_o and stored_quantity_o for one cycle with done_o high, and
// must be captured then. While an item runs, busy stays high through the hash
// phase (two key bytes at a time), the fold, and the probes through the
// registered slot RAM, one RAM read a cycle, plus a step to see the last read;
// done_o is high in the first cycle in which busy is low, and a new item may
// start in that cycle. Slot valid bits clear at reset, so no clearing pass is
// needed. The user must write probe_mode through cfg_we_i/cfg_wdata_i only
// while busy is low; the block itself does not enforce this.
`timescale 1ns / 1ps

module open_address_hash_table import oaht_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ModeW-1:0]    cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic                opcode_i,
  input  logic [HalfKeyW-1:0] key_high_i,
  input  logic [HalfKeyW-1:0] key_low_i,
  input  logic [QtyW-1:0]     add_quantity_i,
  output logic                done_o,
  output logic [StatusW-1:0]  status_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [QtyW-1:0]     stored_quantity_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  oaht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oaht_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (opcode_i),
    .key_high_i        (key_high_i),
    .key_low_i         (key_low_i),
    .add_quantity_i    (add_quantity_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_o            (slot_o),
    .stored_quantity_o (stored_quantity_o)
  );

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but busy not raised");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result strobe outside end of an item");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == StatNotFound || status_o == StatFull)
      |-> slot_o == '0 && stored_quantity_o == '0)
    else $error("miss or full result carries slot data");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

FILE: design/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module oaht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/oaht_ctrl.sv
// Sequencing state machine: hash, fold, probe, finish.
`timescale 1ns / 1ps

module oaht_ctrl import oaht_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StHash  = 4'b0010,
    StFold  = 4'b0100,
    StProbe = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StHash;
        end
      end
      StHash: begin
        cmd_o.hash = 1'b1;
        if (sts_i.hash_last) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        state_d    = StProbe;
      end
      StProbe: begin
        cmd_o.probe = 1'b1;
        if (sts_i.hit || sts_i.exhausted) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

FILE: design/oaht_dp.sv
// Datapath: hash, probe address generation, slot store, compare and result registers.
`timescale 1ns / 1ps

module oaht_dp import oaht_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic [ModeW-1:0]    cfg_wdata_i,
  input  logic                opcode_i,
  input  logic [HalfKeyW-1:0] key_high_i,
  input  logic [HalfKeyW-1:0] key_low_i,
  input  logic [QtyW-1:0]     add_quantity_i,
  output logic                done_o,
  output logic [StatusW-1:0]  status_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [QtyW-1:0]     stored_quantity_o
);

  localparam int NChunk = (HashW + SlotW - 1) / SlotW;
  localparam int SumW   = SlotW + 4;
  localparam int EntryW = KeyW + QtyW;

  logic [ModeW-1:0]      mode_q;
  logic                  op_q;
  logic [KeyW-1:0]       key_q;
  logic [QtyW-1:0]       qty_q;
  logic [HashW-1:0]      hash_q, hash_d;
  logic [HcntW-1:0]      hcnt_q;
  logic [SlotW-1:0]      idx_q, step_q, sq_q, adv;
  logic [ProbeW-1:0]     probe_q;
  logic                  s1_vld_q, s1_last_q, s1_occ_q;
  logic [SlotW-1:0]      s1_idx_q;
  logic [TableSlots-1:0] valid_q;
  logic                  done_q;
  logic [StatusW-1:0]    status_q, status_d;
  logic [SlotW-1:0]      slot_q, slot_d;
  logic [QtyW-1:0]       sqty_q, sqty_d;

  logic [15:0]              pair;
  logic [NChunk*SlotW-1:0]  hash_pad;
  logic [SumW-1:0]          fsum, fold1;
  logic [SlotW:0]           fold2;
  logic [SlotW-1:0]         hmod;
  logic [EntryW-1:0]        rdata, wdata;
  logic [KeyW-1:0]          rd_key;
  logic [QtyW-1:0]          rd_qty, sat_qty;
  logic [QtyW:0]            qty_sum;
  logic                     match, hit, exhausted, we;

  // hash: two key bytes per cycle, shift-by-4-and-add
  assign pair   = key_q[KeyW - 1 - 16 * hcnt_q -: 16];
  assign hash_d = (hash_q << 8) + (HashW'(pair[15:8]) << 4) + HashW'(pair[7:0]);

  // hash mod (TableSlots-1) by folding SlotW-bit chunks
  assign hash_pad = (NChunk * SlotW)'(hash_q);

  always_comb begin
    fsum = '0;
    for (int c = 0; c < NChunk; c++) begin
      fsum = fsum + SumW'(hash_pad[c*SlotW +: SlotW]);
    end
    fold1 = SumW'(fsum[SlotW-1:0]) + (fsum >> SlotW);
    fold2 = (SlotW + 1)'(fold1[SlotW-1:0]) + (SlotW + 1)'(fold1 >> SlotW);
    if (fold2 >= (SlotW + 1)'(TableSlots - 1)) begin
      hmod = SlotW'(fold2 - (SlotW + 1)'(TableSlots - 1));
    end else begin
      hmod = fold2[SlotW-1:0];
    end
  end

  always_comb begin
    case (mode_q)
      ModeQuad:   adv = sq_q;
      ModeDouble: adv = step_q;
      default:    adv = SlotW'(1);
    endcase
  end

  oaht_ram #(
    .Width (EntryW),
    .Depth (TableSlots)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_idx_q),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign rd_key    = rdata[EntryW-1:QtyW];
  assign rd_qty    = rdata[QtyW-1:0];
  assign match     = (rd_key == key_q);
  assign hit       = s1_vld_q && (!s1_occ_q || match);
  assign exhausted = s1_vld_q && s1_last_q && !hit;
  assign qty_sum   = {1'b0, rd_qty} + {1'b0, qty_q};
  assign sat_qty   = qty_sum[QtyW] ? {QtyW{1'b1}} : qty_sum[QtyW-1:0];
  assign we        = cmd_i.finish && (op_q == OpInsert) && hit;
  assign wdata     = {key_q, (s1_occ_q ? sat_qty : qty_q)};

  assign sts_o.hash_last = (hcnt_q == HcntW'(HashCycles - 1));
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = exhausted;

  always_comb begin
    status_d = (op_q == OpLookup) ? StatNotFound : StatFull;
    slot_d   = '0;
    sqty_d   = '0;
    if (hit) begin
      if (op_q == OpLookup) begin
        if (s1_occ_q) begin
          status_d = StatFound;
          slot_d   = s1_idx_q;
          sqty_d   = rd_qty;
        end
      end else if (s1_occ_q) begin
        status_d = StatAdded;
        slot_d   = s1_idx_q;
        sqty_d   = sat_qty;
      end else begin
        status_d = StatInserted;
        slot_d   = s1_idx_q;
        sqty_d   = qty_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeLinear;
      hcnt_q   <= '0;
      probe_q  <= '0;
      s1_vld_q <= 1'b0;
      valid_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        hcnt_q <= '0;
      end else if (cmd_i.hash) begin
        hcnt_q <= hcnt_q + HcntW'(1);
      end
      if (cmd_i.fold) begin
        probe_q  <= '0;
        s1_vld_q <= 1'b0;
      end else if (cmd_i.probe) begin
        probe_q  <= probe_q + ProbeW'(1);
        s1_vld_q <= !cmd_i.finish && (probe_q < ProbeW'(TableSlots));
      end
      if (we) begin
        valid_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      key_q  <= {key_high_i, key_low_i};
      qty_q  <= add_quantity_i;
      hash_q <= '0;
    end else if (cmd_i.hash) begin
      hash_q <= hash_d;
    end
    if (cmd_i.fold) begin
      idx_q  <= hash_q[SlotW-1:0];
      step_q <= hmod + SlotW'(1);
      sq_q   <= SlotW'(1);
    end else if (cmd_i.probe) begin
      s1_idx_q  <= idx_q;
      s1_occ_q  <= valid_q[idx_q];
      s1_last_q <= (probe_q == ProbeW'(TableSlots - 1));
      idx_q     <= idx_q + adv;
      sq_q      <= sq_q + {probe_q[SlotW-2:0], 1'b0} + SlotW'(3);
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      sqty_q   <= sqty_d;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign slot_o            = slot_q;
  assign stored_quantity_o = sqty_q;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the open-addressed hash table: directed and random items.
`timescale 1ns / 1ps

module testbench;
  import oaht_pkg::*;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int CycleLimit = 1000000;
  localparam int PoolSize   = 48;

  typedef struct packed {
    logic                op;
    logic [HalfKeyW-1:0] kh;
    logic [HalfKeyW-1:0] kl;
    logic [QtyW-1:0]     qty;
  } op_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [QtyW-1:0]    qty;
  } answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [ModeW-1:0]    cfg_wdata = '0;
  logic                start = 1'b0;
  logic                busy;
  logic                opcode = 1'b0;
  logic [HalfKeyW-1:0] key_high = '0;
  logic [HalfKeyW-1:0] key_low = '0;
  logic [QtyW-1:0]     add_quantity = '0;
  logic                done;
  logic [StatusW-1:0]  status;
  logic [SlotW-1:0]    slot;
  logic [QtyW-1:0]     stored_quantity;

  open_address_hash_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode),
    .key_high_i        (key_high),
    .key_low_i         (key_low),
    .add_quantity_i    (add_quantity),
    .done_o            (done),
    .status_o          (status),
    .slot_o            (slot),
    .stored_quantity_o (stored_quantity)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the slot store
  bit              tbl_valid [TableSlots];
  logic [KeyW-1:0] tbl_key   [TableSlots];
  logic [QtyW-1:0] tbl_qty   [TableSlots];
  logic [ModeW-1:0] probe_mode_now = ModeLinear;

  op_item_t ops_to_send[$];
  answer_t  answers_due[$];
  op_item_t cur_item = '0;
  int       sender_gap_pct = 0;
  int       errors = 0;
  int       cycle_count = 0;

  logic [HalfKeyW-1:0] pool_kh [PoolSize];
  logic [HalfKeyW-1:0] pool_kl [PoolSize];

  function automatic answer_t predict_table_access(op_item_t it);
    answer_t          a;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] h;
    logic [7:0]       kbyte;
    int unsigned      idx;
    int unsigned      step2;
    int unsigned      i;
    logic [QtyW:0]    sum;
    bit               lookup;
    key = {it.kh, it.kl};
    h = '0;
    for (int n = 0; n < KeyBytes; n++) begin
      kbyte = '0;
      if (n < 12) kbyte = key[KeyW-1-8*n -: 8];
      h = (h << 4) + HashW'(kbyte);
    end
    idx    = h % TableSlots;
    step2  = 1 + h % (TableSlots - 1);
    lookup = (it.op == OpLookup);
    a.status = lookup ? StatNotFound : StatFull;
    a.slot   = '0;
    a.qty    = '0;
    for (int p = 0; p < TableSlots; p++) begin
      if (!tbl_valid[idx]) begin
        if (!lookup) begin
          tbl_valid[idx] = 1'b1;
          tbl_key[idx]   = key;
          tbl_qty[idx]   = it.qty;
          a.status = StatInserted;
          a.slot   = SlotW'(idx);
          a.qty    = it.qty;
        end
        break;
      end
      if (tbl_key[idx] == key) begin
        if (!lookup) begin
          sum = {1'b0, tbl_qty[idx]} + {1'b0, it.qty};
          tbl_qty[idx] = sum[QtyW] ? '1 : sum[QtyW-1:0];
          a.status = StatAdded;
        end else begin
          a.status = StatFound;
        end
        a.slot = SlotW'(idx);
        a.qty  = tbl_qty[idx];
        break;
      end
      case (probe_mode_now)
        ModeQuad: begin
          i = p + 1;
          idx = (idx + (i * i) % TableSlots) % TableSlots;
        end
        ModeDouble: idx = (idx + step2) % TableSlots;
        default: idx = (idx + 1) % TableSlots;
      endcase
    end
    return a;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic send;
    if (rst_ni) begin
      send = start;
      if (start && !busy) begin
        answers_due.push_back(predict_table_access(cur_item));
        send = 1'b0;
      end
      if (!send && ops_to_send.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        cur_item = ops_to_send.pop_front();
        send = 1'b1;
      end
      start        <= send;
      opcode       <= cur_item.op;
      key_high     <= cur_item.kh;
      key_low      <= cur_item.kl;
      add_quantity <= cur_item.qty;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result: status %0d slot %0d stored_quantity %0d",
               status, slot, stored_quantity);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          errors++;
        end
        if (stored_quantity !== want.qty) begin
          $error("stored_quantity: expected %0d, got %0d", want.qty, stored_quantity);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[open_address_hash_table] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (ops_to_send.size() != 0 || start || answers_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic [ModeW-1:0] mode, input int gap);
    wait_idle();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    probe_mode_now = mode;
    sender_gap_pct = gap;
    @(negedge clk_i);
  endtask

  task automatic push_op(input logic op, input logic [HalfKeyW-1:0] kh,
                         input logic [HalfKeyW-1:0] kl, input logic [QtyW-1:0] qty);
    op_item_t it;
    it.op  = op;
    it.kh  = kh;
    it.kl  = kl;
    it.qty = qty;
    ops_to_send.push_back(it);
  endtask

  function automatic op_item_t random_op();
    op_item_t it;
    int       k;
    int       r;
    k = $urandom_range(0, PoolSize - 1);
    r = $urandom_range(0, 99);
    it.op = (r >= 45 && r < 90) ? OpLookup : OpInsert;
    if (r < 80) begin
      it.kh = pool_kh[k];
      it.kl = pool_kl[k];
    end else begin
      // fresh keys: half are lookups that miss, half are inserts that claim new slots until the table fills
      it.kh = HalfKeyW'({$urandom, $urandom});
      it.kl = HalfKeyW'({$urandom, $urandom});
    end
    case ($urandom_range(0, 9))
      0:       it.qty = '0;
      1:       it.qty = '1;
      2, 3, 4: it.qty = QtyW'($urandom);
      default: it.qty = QtyW'($urandom_range(1, 200));
    endcase
    return it;
  endfunction

  initial begin
    logic [ModeW-1:0] modes [6];
    int               gaps  [6];
    modes = '{ModeLinear, ModeQuad, ModeDouble, ModeUnused, ModeQuad, ModeDouble};
    gaps  = '{31, 31, 55, 55, 0, 0};

    // pool keys crowd a few home slots
    for (int k = 0; k < PoolSize; k++) begin
      pool_kh[k] = HalfKeyW'({$urandom, $urandom});
      if (k % 3 == 0) pool_kl[k] = HalfKeyW'({$urandom, $urandom});
      else pool_kl[k] = {32'($urandom), 16'($urandom_range(0, 3) * 16'h0101)};
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: every key below homes to slot 0 except the all-ones key (slot 111)
    set_mode(ModeLinear, 31);
    push_op(OpLookup, '0, '0, '1);
    push_op(OpInsert, '0, '0, '0);
    push_op(OpInsert, 48'h0000_0000_0001, 48'h0, 16'd5);
    push_op(OpInsert, 48'h0, 48'h0000_0001_0000, 16'd7);
    push_op(OpLookup, 48'h0, 48'h0000_0001_0000, '0);
    push_op(OpInsert, '1, '1, '1);
    push_op(OpInsert, '1, '1, 16'd1);
    push_op(OpInsert, '1, '1, '0);
    push_op(OpLookup, '1, '1, '0);
    push_op(OpInsert, 48'h0000_0000_0001, 48'h0, '1);
    push_op(OpLookup, 48'hFF00_0000_0000, 48'h0, '0);
    push_op(OpLookup, '0, '0, '0);

    set_mode(ModeUnused, 31);
    push_op(OpInsert, 48'hFF00_0000_0000, 48'h0, 16'd3);
    push_op(OpLookup, 48'hFF00_0000_0000, 48'h0, '0);

    set_mode(ModeDouble, 31);
    push_op(OpLookup, 48'h0, 48'h0000_0001_0000, '0);
    push_op(OpInsert, 48'h0, 48'h8000_0000_0000, 16'd9);
    push_op(OpLookup, 48'h0, 48'h8000_0000_0000, '0);

    set_mode(ModeQuad, 31);
    push_op(OpInsert, 48'h1234_5678_9ABC, 48'h0, 16'd11);
    push_op(OpLookup, 48'h1234_5678_9ABC, 48'h0, '0);
    push_op(OpLookup, 48'h0000_0000_0001, 48'h0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      set_mode(modes[ph], gaps[ph]);
      for (int n = 0; n < 225; n++) ops_to_send.push_back(random_op());
    end

    wait_idle();
    repeat (150) @(negedge clk_i);
    if (errors == 0) $display("[open_address_hash_table] OK");
    else $display("[open_address_hash_table] ERROR");
    $finish;
  end

endmodule

FILE: files.f
design/oaht_pkg.sv
design/oaht_ram.sv
design/oaht_ctrl.sv
design/oaht_dp.sv
design/open_address_hash_table.sv
tb/sv/testbench.sv
